// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ded_pkg.sv =====
// Shared constants of the DNA edit distance block.
`timescale 1ns / 1ps
package ded_pkg;
  // symbols are A=0 T=1 G=2 C=3, two bits each, symbol 0 lowest
  localparam int SYM_W = 2;
  localparam int DIST_W = 4;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;
endpackage

// ===== rtl/ded_pair_if.sv =====
// Input channel: a pair of packed DNA strings.
`timescale 1ns / 1ps
interface ded_pair_if
  import ded_pkg::*;
#(
  parameter int STRING_LEN = 8
);
  localparam int STR_W = SYM_W * STRING_LEN;
  logic             valid;
  logic             ready;
  logic [STR_W-1:0] first_string;
  logic [STR_W-1:0] second_string;
  modport source (output valid, output first_string, output second_string, input ready);
  modport sink (input valid, input first_string, input second_string, output ready);
endinterface

// ===== rtl/ded_dist_if.sv =====
// Output channel: one edit distance.
`timescale 1ns / 1ps
interface ded_dist_if
  import ded_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

// ===== rtl/dna_edit_distance.sv =====
// Top level: systolic edit distance pipeline over DNA string pairs.
//
// Channels: pairs (sink) carries first_string and second_string, each
// STRING_LEN symbols of two bits, symbol 0 in the low bits. result (source)
// carries one 4-bit distance per pair, in arrival order, saturated at 15.
// An item moves on a rising edge with valid and ready both high.
//
// The grid is swept one anti-diagonal per cell: a chain of 2*STRING_LEN
// cells, each registering its diagonal and the one before it. A new pair
// can be taken every cycle while result is not stalled, set by the
// single-diagonal cell step.
//
// Reset clears the valid bit of every cell; the pipeline then is empty
// and ready is high. When result is stalled the last cell holds its item,
// each cell accepts while it is empty or its successor moves, so empty
// slots fill up and pairs keep being taken until the chain is full.
`timescale 1ns / 1ps
module dna_edit_distance
  import ded_pkg::*;
#(
  parameter int STRING_LEN = 8
) (
  input  logic          clk,
  input  logic          rst,
  ded_pair_if.sink      pairs,
  ded_dist_if.source    result
);

  localparam int N     = STRING_LEN;
  localparam int DW    = $clog2(N + 1);
  localparam int NS    = 2 * N;
  localparam int STR_W = SYM_W * N;

  logic                 v   [0:NS];
  logic                 rdy [0:NS];
  logic [STR_W-1:0]     fs  [0:NS];
  logic [STR_W-1:0]     ss  [0:NS];
  logic [N:0][DW-1:0]   d1  [0:NS];
  logic [N:0][DW-1:0]   d2  [0:NS];
  logic [DW+DIST_W-1:0] dist_ext;

  assign v[0]        = pairs.valid;
  assign pairs.ready = rdy[0];
  assign fs[0]       = pairs.first_string;
  assign ss[0]       = pairs.second_string;
  assign d1[0]       = '0;
  assign d2[0]       = '0;

  for (genvar k = 1; k <= NS; k++) begin : g_cell
    ded_cell #(
      .N    (N),
      .DW   (DW),
      .DIAG (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (v[k-1]),
      .in_ready   (rdy[k-1]),
      .in_first   (fs[k-1]),
      .in_second  (ss[k-1]),
      .in_diag1   (d1[k-1]),
      .in_diag2   (d2[k-1]),
      .out_valid  (v[k]),
      .out_ready  (rdy[k]),
      .out_first  (fs[k]),
      .out_second (ss[k]),
      .out_diag1  (d1[k]),
      .out_diag2  (d2[k])
    );
  end

  assign rdy[NS]      = result.ready;
  assign result.valid = v[NS];
  assign dist_ext     = (DW + DIST_W)'(d1[NS][N]);
  assign result.distance = (dist_ext > (DW + DIST_W)'(DIST_SAT)) ? DIST_SAT
                                                                 : dist_ext[DIST_W-1:0];

endmodule

// ===== rtl/ded_cell.sv =====
// One pipeline cell: computes one anti-diagonal of the edit distance grid.
`timescale 1ns / 1ps
module ded_cell
  import ded_pkg::*;
#(
  parameter int N    = 8,
  parameter int DW   = 4,
  parameter int DIAG = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SYM_W*N-1:0]    in_first,
  input  logic [SYM_W*N-1:0]    in_second,
  input  logic [N:0][DW-1:0]    in_diag1,
  input  logic [N:0][DW-1:0]    in_diag2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_W*N-1:0]    out_first,
  output logic [SYM_W*N-1:0]    out_second,
  output logic [N:0][DW-1:0]    out_diag1,
  output logic [N:0][DW-1:0]    out_diag2
);

  logic [N:0][DW-1:0] cur;

  // row index i, column DIAG - i
  for (genvar i = 0; i <= N; i++) begin : g_row
    localparam int J = DIAG - i;
    if (J < 0 || J > N) begin : g_off
      assign cur[i] = '0;
    end else if (i == 0) begin : g_top
      assign cur[i] = DW'(J);
    end else if (J == 0) begin : g_left
      assign cur[i] = DW'(i);
    end else begin : g_inner
      logic          match;
      logic [DW-1:0] up, lft, dg, m1, m2, cell_val;
      always_comb begin
        match = in_first[SYM_W*(i-1) +: SYM_W] == in_second[SYM_W*(J-1) +: SYM_W];
        up    = in_diag1[i-1];
        lft   = in_diag1[i];
        dg    = in_diag2[i-1];
        m1    = (up < lft) ? up : lft;
        m2    = (m1 < dg) ? m1 : dg;
        cell_val = match ? dg : m2 + DW'(1);
      end
      assign cur[i] = cell_val;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_first  <= in_first;
      out_second <= in_second;
      out_diag1  <= cur;
      out_diag2  <= in_diag1;
    end
  end

endmodule

// ===== rtl/ded_checker.sv =====
// Port-level checker for the DNA edit distance block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ded_checker
  import ded_pkg::*;
#(
  parameter int STRING_LEN = 8
) (
  input logic              clk,
  input logic              rst,
  input logic              pairs_ready,
  input logic              result_valid,
  input logic              result_ready,
  input logic [DIST_W-1:0] distance
);

  localparam int MAX_D = (STRING_LEN < int'(DIST_SAT)) ? STRING_LEN : int'(DIST_SAT);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid, "result valid after reset")
  `ASSERT_IMPLY(a_dist_bound, clk, rst, result_valid, int'(distance) <= MAX_D, "distance too large")
  `ASSERT_IMPLY(a_empty_ready, clk, rst, !result_valid, pairs_ready, "not ready with empty output")
  `ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(distance), "stalled result changed")

endmodule

bind dna_edit_distance ded_checker #(
  .STRING_LEN (STRING_LEN)
) u_ded_checker (
  .clk          (clk),
  .rst          (rst),
  .pairs_ready  (pairs.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .distance     (result.distance)
);
